FILE: hdl/sorted_key_value_table_macros.svh
// ----------------------------------------------------------------------------
// sorted_key_value_table assertion macros
// Concurrent check shorthands used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SKVT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SKVT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Word types, command and status codes for the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 16;
  localparam int VALUE_W = 32;
  localparam int CNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_GET      = 3'd2,
    CMD_CONTAINS = 3'd3,
    CMD_REPLACE  = 3'd4,
    CMD_TRAVERSE = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] new_value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] read_value;
    logic [CNT_W-1:0]   entry_count;
    logic               last;
  } rsp_t;

  // result of the shared key comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

FILE: hdl/skvt_mem.sv
// ----------------------------------------------------------------------------
// skvt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_mem #(
  parameter int W     = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/skvt_cmp.sv
// ----------------------------------------------------------------------------
// skvt_cmp
// Shared unsigned key comparator used on every step of the search.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_cmp #(
  parameter int W = 16
) (
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output skvt_pkg::cmp_t        res
);

  assign res.lt = (a < b);
  assign res.eq = (a == b);

endmodule

`default_nettype wire

FILE: hdl/sorted_key_value_table.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Bounded dictionary of unique keys kept in ascending order, with values.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Results come out one per
// done strobe, held for that one cycle only; the receiver cannot stall them.
// Add, remove, get, contains and replace first scan the stored keys from the
// smallest up through one memory read port and one comparator, reading each
// key in S_SRD and comparing it in S_SCMP, and stop at the first key not
// below the search key or when the scan runs past the last entry. S_ACT then
// decides the command. After it, add moves each larger entry up one slot and
// remove moves each later entry down, a read and a write per entry moved; an
// add then writes the new entry in S_INS, and a remove ends in S_DNRD.
// Traverse reads each value in S_TRD and emits it in S_TOUT, one per done
// strobe, last set on the final one. Clear, traverse of an empty table and
// the unused code answer straight from idle without going busy.
`default_nettype none

`include "sorted_key_value_table_macros.svh"

module sorted_key_value_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire skvt_pkg::req_t  req,
  output logic                 busy,
  output logic                 done,
  output skvt_pkg::rsp_t       rsp
);

  localparam int KW = (KEY_BITS < skvt_pkg::KEY_W) ? KEY_BITS : skvt_pkg::KEY_W;
  localparam int VW = (VALUE_BITS < skvt_pkg::VALUE_W) ? VALUE_BITS : skvt_pkg::VALUE_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_ACT, S_UPRD, S_UPWR, S_INS, S_DNRD, S_DNWR,
    S_TRD, S_TOUT
  } state_t;

  state_t            state;
  skvt_pkg::cmd_t    cmd;
  logic [KW-1:0]     key;
  logic [VW-1:0]     value;
  logic [VW-1:0]     found;
  logic [OW-1:0]     occ;
  logic [OW-1:0]     idx;
  logic [OW-1:0]     pos;
  logic              hit;

  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic              key_we;
  logic              val_we;
  logic [KW-1:0]     key_wdata;
  logic [VW-1:0]     val_wdata;
  logic [KW-1:0]     key_rd;
  logic [VW-1:0]     val_rd;
  skvt_pkg::cmp_t    cmp;

  logic [OW-1:0]     idx_dec;
  logic [OW-1:0]     idx_inc;

  assign idx_dec = idx - OW'(1);
  assign idx_inc = idx + OW'(1);
  assign busy    = (state != S_IDLE);

  skvt_mem #(.W(KW), .DEPTH(CAPACITY)) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rd)
  );

  skvt_mem #(.W(VW), .DEPTH(CAPACITY)) u_values (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rd)
  );

  skvt_cmp #(.W(KW)) u_cmp (
    .a   (key_rd),
    .b   (key),
    .res (cmp)
  );

  // read address per state; data shows up the following cycle
  always_comb begin
    case (state)
      S_UPRD:  raddr = idx_dec[AW-1:0];
      S_DNRD:  raddr = idx_inc[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  always_comb begin
    key_we    = 1'b0;
    val_we    = 1'b0;
    waddr     = idx[AW-1:0];
    key_wdata = key_rd;
    val_wdata = val_rd;
    case (state)
      S_UPWR, S_DNWR: begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
      S_INS: begin
        key_we    = 1'b1;
        val_we    = 1'b1;
        waddr     = pos[AW-1:0];
        key_wdata = key;
        val_wdata = value;
      end
      S_ACT: begin
        waddr     = pos[AW-1:0];
        val_wdata = value;
        val_we    = (cmd == skvt_pkg::CMD_REPLACE) && hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd   <= req.cmd;
            key   <= req.key[KW-1:0];
            value <= req.new_value[VW-1:0];
            idx   <= '0;
            rsp.status      <= skvt_pkg::ST_OK;
            rsp.read_value  <= '0;
            rsp.entry_count <= skvt_pkg::CNT_W'(occ);
            rsp.last        <= 1'b1;
            case (req.cmd)
              skvt_pkg::CMD_ADD, skvt_pkg::CMD_REMOVE, skvt_pkg::CMD_GET,
              skvt_pkg::CMD_CONTAINS, skvt_pkg::CMD_REPLACE: begin
                state <= S_SRD;
              end
              skvt_pkg::CMD_TRAVERSE: begin
                if (occ == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_TRD;
                end
              end
              skvt_pkg::CMD_CLEAR: begin
                occ             <= '0;
                rsp.entry_count <= '0;
                done            <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SRD: begin
          if (idx == occ) begin
            pos   <= idx;
            hit   <= 1'b0;
            state <= S_ACT;
          end else begin
            state <= S_SCMP;
          end
        end
        S_SCMP: begin
          found <= val_rd;
          if (cmp.lt) begin
            idx   <= idx_inc;
            state <= S_SRD;
          end else begin
            pos   <= idx;
            hit   <= cmp.eq;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          state <= S_IDLE;
          case (cmd)
            skvt_pkg::CMD_ADD: begin
              if (hit) begin
                rsp.status <= skvt_pkg::ST_DUP;
                done       <= 1'b1;
              end else if (occ == OW'(CAPACITY)) begin
                rsp.status <= skvt_pkg::ST_FULL;
                done       <= 1'b1;
              end else begin
                idx   <= occ;
                state <= S_UPRD;
              end
            end
            skvt_pkg::CMD_REMOVE: begin
              if (hit) begin
                idx   <= pos;
                state <= S_DNRD;
              end else begin
                rsp.status <= skvt_pkg::ST_MISSING;
                done       <= 1'b1;
              end
            end
            skvt_pkg::CMD_GET: begin
              rsp.status     <= hit ? skvt_pkg::ST_OK : skvt_pkg::ST_MISSING;
              rsp.read_value <= hit ? skvt_pkg::VALUE_W'(found) : '0;
              done           <= 1'b1;
            end
            default: begin
              // contains, replace (value written by the port logic)
              rsp.status <= hit ? skvt_pkg::ST_OK : skvt_pkg::ST_MISSING;
              done       <= 1'b1;
            end
          endcase
        end
        S_UPRD: begin
          state <= (idx == pos) ? S_INS : S_UPWR;
        end
        S_UPWR: begin
          idx   <= idx_dec;
          state <= S_UPRD;
        end
        S_INS: begin
          occ             <= occ + OW'(1);
          rsp.entry_count <= skvt_pkg::CNT_W'(occ + OW'(1));
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        S_DNRD: begin
          if (idx_inc >= occ) begin
            occ             <= occ - OW'(1);
            rsp.entry_count <= skvt_pkg::CNT_W'(occ - OW'(1));
            done            <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_DNWR;
          end
        end
        S_DNWR: begin
          idx   <= idx_inc;
          state <= S_DNRD;
        end
        S_TRD: begin
          state <= S_TOUT;
        end
        S_TOUT: begin
          rsp.read_value <= skvt_pkg::VALUE_W'(val_rd);
          rsp.last       <= (idx_inc == occ);
          done           <= 1'b1;
          idx            <= idx_inc;
          state          <= (idx_inc == occ) ? S_IDLE : S_TRD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SKVT_ASSERT_IMP(a_occ_bound, 1'b1, occ <= OW'(CAPACITY), "occupancy above capacity")
  `SKVT_ASSERT_IMP(a_mid_stream_busy, done && !rsp.last, busy, "idle inside a traverse")
  `SKVT_ASSERT_NXT(a_stream_pace, done && !rsp.last, !done ##1 done, "traverse pacing broken")
  `SKVT_ASSERT_IMP(a_full_count, done && (rsp.status == skvt_pkg::ST_FULL), rsp.entry_count == skvt_pkg::CNT_W'(CAPACITY), "full reported below capacity")

endmodule

`default_nettype wire

FILE: tb/sorted_key_value_table_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_tb
// Self-checking bench for the sorted key/value table. Words go in over the
// start/busy handshake and every done strobe is checked against a local
// model of the sorted table: directed cases first, then random traffic with
// a small key pool so the table fills, empties and overflows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_value_table_tb;

  localparam int DEPTH        = 16;
  localparam int POOL_SIZE    = 24;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 10;
  localparam logic [skvt_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst;
  logic start;
  skvt_pkg::req_t req;
  logic busy;
  logic done;
  skvt_pkg::rsp_t rsp;

  // local copy of the table
  logic [skvt_pkg::KEY_W-1:0]   table_key [DEPTH];
  logic [skvt_pkg::VALUE_W-1:0] table_val [DEPTH];
  int                           table_count;

  skvt_pkg::rsp_t pending_rsp[$];
  logic [skvt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];

  int idle_pct;
  int words_sent;
  int results_checked;
  int mismatches;
  int unexpected;
  int full_rejects;
  int full_traversals;
  int stall_cycles;

  sorted_key_value_table u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always #10 clk = ~clk;

  // Expected results for one accepted word; updates the local table.
  function automatic void predict_word(input skvt_pkg::req_t w);
    int             pos;
    logic           hit;
    skvt_pkg::rsp_t r;
    pos = 0;
    while (pos < table_count && table_key[pos] < w.key) pos++;
    hit = (pos < table_count) && (table_key[pos] == w.key);
    r = '0;
    r.status = skvt_pkg::ST_OK;
    r.last = 1'b1;
    case (w.cmd)
      skvt_pkg::CMD_ADD: begin
        if (hit) begin
          r.status = skvt_pkg::ST_DUP;
        end else if (table_count >= DEPTH) begin
          r.status = skvt_pkg::ST_FULL;
          full_rejects++;
        end else begin
          for (int i = table_count; i > pos; i--) begin
            table_key[i] = table_key[i-1];
            table_val[i] = table_val[i-1];
          end
          table_key[pos] = w.key;
          table_val[pos] = w.new_value;
          table_count++;
        end
      end
      skvt_pkg::CMD_REMOVE: begin
        if (!hit) begin
          r.status = skvt_pkg::ST_MISSING;
        end else begin
          for (int i = pos; i + 1 < table_count; i++) begin
            table_key[i] = table_key[i+1];
            table_val[i] = table_val[i+1];
          end
          table_count--;
        end
      end
      skvt_pkg::CMD_GET: begin
        if (hit) r.read_value = table_val[pos];
        else r.status = skvt_pkg::ST_MISSING;
      end
      skvt_pkg::CMD_CONTAINS: begin
        if (!hit) r.status = skvt_pkg::ST_MISSING;
      end
      skvt_pkg::CMD_REPLACE: begin
        if (hit) table_val[pos] = w.new_value;
        else r.status = skvt_pkg::ST_MISSING;
      end
      skvt_pkg::CMD_TRAVERSE: begin
        if (table_count == DEPTH) full_traversals++;
        for (int i = 0; i < table_count; i++) begin
          r.read_value = table_val[i];
          r.entry_count = skvt_pkg::CNT_W'(table_count);
          r.last = (i + 1 == table_count);
          pending_rsp.push_back(r);
        end
      end
      skvt_pkg::CMD_CLEAR: table_count = 0;
      default: ;
    endcase
    // a traverse of a non-empty table has queued its stream already
    if (!(w.cmd == skvt_pkg::CMD_TRAVERSE && table_count != 0)) begin
      r.entry_count = skvt_pkg::CNT_W'(table_count);
      pending_rsp.push_back(r);
    end
  endfunction

  task automatic send_word(input skvt_pkg::cmd_t c,
                           input logic [skvt_pkg::KEY_W-1:0] k,
                           input logic [skvt_pkg::VALUE_W-1:0] v);
    skvt_pkg::req_t w;
    w.cmd = c;
    w.key = k;
    w.new_value = v;
    start <= 1'b1;
    req <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_word(w);
    words_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [skvt_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && table_count > 0) return table_key[$urandom_range(0, table_count - 1)];
    if (r < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return skvt_pkg::KEY_W'($urandom);
  endfunction

  function automatic logic [skvt_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_table();
    send_word(skvt_pkg::CMD_REMOVE, 16'h1234, 32'h0);
    send_word(skvt_pkg::CMD_TRAVERSE, 16'h0, 32'h0);
    send_word(skvt_pkg::CMD_GET, 16'hFFFF, 32'h0);
    send_word(skvt_pkg::CMD_REPLACE, 16'h0000, 32'hFFFF_FFFF);
    send_word(skvt_pkg::cmd_t'(CMD_UNUSED), 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_basic_ops();
    send_word(skvt_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(skvt_pkg::CMD_ADD, 16'h0000, 32'h0000_0000);
    send_word(skvt_pkg::CMD_ADD, 16'h8000, 32'hA5A5_A5A5);
    send_word(skvt_pkg::CMD_ADD, 16'h8000, 32'h1111_1111);
    send_word(skvt_pkg::CMD_GET, 16'hFFFF, 32'h0);
    send_word(skvt_pkg::CMD_CONTAINS, 16'h0000, 32'h0);
    send_word(skvt_pkg::CMD_CONTAINS, 16'h7FFF, 32'h0);
    send_word(skvt_pkg::CMD_REPLACE, 16'h8000, 32'h5A5A_5A5A);
    send_word(skvt_pkg::CMD_GET, 16'h8000, 32'h0);
    send_word(skvt_pkg::CMD_TRAVERSE, 16'h0, 32'h0);
    send_word(skvt_pkg::CMD_REMOVE, 16'h0000, 32'h0);
    send_word(skvt_pkg::CMD_REMOVE, 16'hFFFF, 32'h0);
    send_word(skvt_pkg::CMD_TRAVERSE, 16'h0, 32'h0);
    send_word(skvt_pkg::CMD_CLEAR, 16'h0, 32'h0);
  endtask

  // descending adds make every insert shift the whole table
  task automatic test_full_table();
    for (int i = 0; i < DEPTH; i++)
      send_word(skvt_pkg::CMD_ADD, 16'hF000 - skvt_pkg::KEY_W'(i * 16'h0F00), pick_value());
    send_word(skvt_pkg::CMD_ADD, 16'h0001, 32'hDEAD_BEEF);
    send_word(skvt_pkg::CMD_ADD, 16'hF000, 32'h0);
    send_word(skvt_pkg::CMD_GET, 16'h0000, 32'h0);
    send_word(skvt_pkg::CMD_REMOVE, 16'h8800, 32'h0);
    send_word(skvt_pkg::CMD_ADD, 16'h8801, 32'hC3C3_C3C3);
    send_word(skvt_pkg::CMD_TRAVERSE, 16'h0, 32'h0);
    send_word(skvt_pkg::CMD_REMOVE, 16'h0000, 32'h0);
    send_word(skvt_pkg::CMD_TRAVERSE, 16'h0, 32'h0);
    send_word(skvt_pkg::CMD_CLEAR, 16'h0, 32'h0);
  endtask

  task automatic test_random_traffic(input int pct, input int n_words);
    int r;
    idle_pct = pct;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = skvt_pkg::KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < n_words; n++) begin
      r = $urandom_range(0, 99);
      if (r < 38) send_word(skvt_pkg::CMD_ADD, pick_key(), pick_value());
      else if (r < 52) send_word(skvt_pkg::CMD_REMOVE, pick_key(), pick_value());
      else if (r < 67) send_word(skvt_pkg::CMD_GET, pick_key(), pick_value());
      else if (r < 77) send_word(skvt_pkg::CMD_CONTAINS, pick_key(), pick_value());
      else if (r < 88) send_word(skvt_pkg::CMD_REPLACE, pick_key(), pick_value());
      else if (r < 95) send_word(skvt_pkg::CMD_TRAVERSE, pick_key(), pick_value());
      else if (r < 97) send_word(skvt_pkg::CMD_CLEAR, pick_key(), pick_value());
      else send_word(skvt_pkg::cmd_t'(CMD_UNUSED), pick_key(), pick_value());
    end
  endtask

  // result checker: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    skvt_pkg::rsp_t exp_rsp;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= MAX_REPORTS)
          $display("unexpected result: status %0d value %h count %0d last %b",
                   rsp.status, rsp.read_value, rsp.entry_count, rsp.last);
      end else begin
        exp_rsp = pending_rsp.pop_front();
        results_checked++;
        if (rsp.status !== exp_rsp.status || rsp.read_value !== exp_rsp.read_value ||
            rsp.entry_count !== exp_rsp.entry_count || rsp.last !== exp_rsp.last) begin
          mismatches++;
          if (mismatches + unexpected <= MAX_REPORTS)
            $display({"mismatch: exp status %0d value %h count %0d last %b, ",
                      "got status %0d value %h count %0d last %b"},
                     exp_rsp.status, exp_rsp.read_value, exp_rsp.entry_count,
                     exp_rsp.last, rsp.status, rsp.read_value, rsp.entry_count,
                     rsp.last);
        end
      end
    end
  end

  // watchdog: cycles with no word in and no result out
  always @(posedge clk) begin
    if ((start && !busy && !rst) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    table_count = 0;
    idle_pct = 0;
    words_sent = 0;
    results_checked = 0;
    mismatches = 0;
    unexpected = 0;
    full_rejects = 0;
    full_traversals = 0;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_basic_ops();
    idle_pct = 27;
    test_full_table();
    test_random_traffic(0, 140);
    test_random_traffic(68, 130);
    test_random_traffic(27, 130);

    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d results checked, %0d mismatches, %0d unexpected",
             words_sent, results_checked, mismatches, unexpected);
    $display("table overflowed %0d times, traversed while full %0d times",
             full_rejects, full_traversals);
    if (mismatches == 0 && unexpected == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
